// File: design/srhs_pkg.sv
// ----------------------------------------------------------------------------
// srhs_pkg - shared types and tables for the SIP request header scanner
// Byte class record, result record, line phases and match strings.
// ----------------------------------------------------------------------------
`default_nettype none

package srhs_pkg;

    localparam int LEN_BITS = 16;
    typedef logic [LEN_BITS-1:0] len_t;
    localparam len_t LEN_MAX = '1;

    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [1:0] METH_UNKNOWN  = 2'd0;
    localparam logic [1:0] METH_INVITE   = 2'd1;
    localparam logic [1:0] METH_REGISTER = 2'd2;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_SDP   = 2'd1;
    localparam logic [1:0] KIND_OTHER = 2'd2;

    typedef enum logic [2:0] {
        PH_NAME,
        PH_TAIL,
        PH_LEAD,
        PH_VALUE,
        PH_SKIP
    } phase_t;

    // one classified input byte
    typedef struct packed {
        logic [7:0] lc;      // case-folded byte
        logic       ws;
        logic       lf;
        logic       cr;
        logic       colon;
        logic       digit;
        logic [3:0] dval;
        logic       last;
    } byte_t;

    typedef struct packed {
        logic [1:0]  method_code;
        logic [15:0] body_offset;
        logic [15:0] body_length;
        logic [1:0]  content_kind;
    } res_t;

    function automatic logic [7:0] pat_invite(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0: r = "i";
            4'd1: r = "n";
            4'd2: r = "v";
            4'd3: r = "i";
            4'd4: r = "t";
            4'd5: r = "e";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pat_register(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0: r = "r";
            4'd1: r = "e";
            4'd2: r = "g";
            4'd3: r = "i";
            4'd4: r = "s";
            4'd5: r = "t";
            4'd6: r = "e";
            4'd7: r = "r";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pat_clen(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0:  r = "c";
            4'd1:  r = "o";
            4'd2:  r = "n";
            4'd3:  r = "t";
            4'd4:  r = "e";
            4'd5:  r = "n";
            4'd6:  r = "t";
            4'd7:  r = "-";
            4'd8:  r = "l";
            4'd9:  r = "e";
            4'd10: r = "n";
            4'd11: r = "g";
            4'd12: r = "t";
            4'd13: r = "h";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pat_ctype(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0:  r = "c";
            4'd1:  r = "o";
            4'd2:  r = "n";
            4'd3:  r = "t";
            4'd4:  r = "e";
            4'd5:  r = "n";
            4'd6:  r = "t";
            4'd7:  r = "-";
            4'd8:  r = "t";
            4'd9:  r = "y";
            4'd10: r = "p";
            4'd11: r = "e";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pat_sdp(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0:  r = "a";
            4'd1:  r = "p";
            4'd2:  r = "p";
            4'd3:  r = "l";
            4'd4:  r = "i";
            4'd5:  r = "c";
            4'd6:  r = "a";
            4'd7:  r = "t";
            4'd8:  r = "i";
            4'd9:  r = "o";
            4'd10: r = "n";
            4'd11: r = "/";
            4'd12: r = "s";
            4'd13: r = "d";
            4'd14: r = "p";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/srhs_front.sv
// ----------------------------------------------------------------------------
// srhs_front - byte classifier
// Folds case and flags whitespace, line feed, CR, colon and digits.
// ----------------------------------------------------------------------------
`default_nettype none

module srhs_front (
    input  wire logic [7:0]    data_byte,
    input  wire logic          last_byte,
    output srhs_pkg::byte_t    cls
);
    import srhs_pkg::*;

    always_comb
    begin
        cls.lc    = (data_byte >= 8'd65 && data_byte <= 8'd90) ? (data_byte | 8'h20) : data_byte;
        cls.ws    = (data_byte == 8'd32) || (data_byte >= 8'd9 && data_byte <= 8'd13);
        cls.lf    = (data_byte == 8'd10);
        cls.cr    = (data_byte == 8'd13);
        cls.colon = (data_byte == CH_COLON);
        cls.digit = (data_byte >= 8'd48 && data_byte <= 8'd57);
        cls.dval  = 4'(data_byte - 8'd48);
        cls.last  = last_byte;
    end

endmodule

`default_nettype wire

// File: design/srhs_byte_q.sv
// ----------------------------------------------------------------------------
// srhs_byte_q - two-entry queue of classified bytes
// Decouples the classifier from the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

module srhs_byte_q (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  srhs_pkg::byte_t    wr_data,
    output logic               full,
    output logic               valid,
    input  wire logic          rd_en,
    output srhs_pkg::byte_t    rd_data
);
    import srhs_pkg::*;

    byte_t      mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign rd_data = mem_reg[rptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;

    always_comb
    begin
        wptr_next = do_wr ? !wptr_reg : wptr_reg;
        rptr_next = do_rd ? !rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: design/srhs_res_q.sv
// ----------------------------------------------------------------------------
// srhs_res_q - two-entry result queue
// Holds finished results until the receiver pops them.
// ----------------------------------------------------------------------------
`default_nettype none

module srhs_res_q (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  srhs_pkg::res_t     wr_data,
    output logic               full,
    output logic               empty,
    input  wire logic          rd_en,
    output srhs_pkg::res_t     rd_data
);
    import srhs_pkg::*;

    res_t       mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wptr_next = do_wr ? !wptr_reg : wptr_reg;
        rptr_next = do_rd ? !rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: design/srhs_scan.sv
// ----------------------------------------------------------------------------
// srhs_scan - header scanner
// Per-byte method, blank-line and header-line tracking; emits one result
// on the last byte of a datagram and then returns to its start state.
// ----------------------------------------------------------------------------
`default_nettype none

module srhs_scan (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  srhs_pkg::byte_t    in_item,
    output logic               in_take,
    input  wire logic          res_full,
    output logic               res_push,
    output srhs_pkg::res_t     res
);
    import srhs_pkg::*;

    len_t       cnt_reg, cnt_next;
    logic [3:0] mm_reg, mm_next;
    logic       inv_reg, inv_next;
    logic       regm_reg, regm_next;
    logic       tok_reg, tok_next;
    logic [1:0] meth_reg, meth_next;
    logic       ifl_reg, ifl_next;
    logic       snl_reg, snl_next;
    len_t       bstart_reg, bstart_next;
    logic       bfound_reg, bfound_next;
    logic [3:0] np_reg, np_next;
    logic       clen_reg, clen_next;
    logic       ctyp_reg, ctyp_next;
    logic       sel_reg, sel_next;
    phase_t     ph_reg, ph_next;
    logic       ldone_reg, ldone_next;
    len_t       lval_reg, lval_next;
    logic       lnum_reg, lnum_next;
    logic       tdone_reg, tdone_next;
    logic [4:0] tpos_reg, tpos_next;
    logic       tbad_reg, tbad_next;
    logic       tgap_reg, tgap_next;
    logic       tany_reg, tany_next;
    logic [1:0] tcls_reg, tcls_next;

    logic                hit_len, hit_type, full_len, full_type, do_line_end, do_tc;
    logic [LEN_BITS+3:0] prod;
    len_t                total, offset, remain, blen;
    byte_t               b;

    assign b        = in_item;
    assign in_take  = in_valid && !res_full;
    assign res_push = in_take && b.last;

    always_comb
    begin
        cnt_next = cnt_reg;       mm_next = mm_reg;       inv_next = inv_reg;
        regm_next = regm_reg;     tok_next = tok_reg;     meth_next = meth_reg;
        ifl_next = ifl_reg;       snl_next = snl_reg;     bstart_next = bstart_reg;
        bfound_next = bfound_reg; np_next = np_reg;       clen_next = clen_reg;
        ctyp_next = ctyp_reg;     sel_next = sel_reg;     ph_next = ph_reg;
        ldone_next = ldone_reg;   lval_next = lval_reg;   lnum_next = lnum_reg;
        tdone_next = tdone_reg;   tpos_next = tpos_reg;   tbad_next = tbad_reg;
        tgap_next = tgap_reg;     tany_next = tany_reg;   tcls_next = tcls_reg;
        hit_len = 1'b0;  hit_type = 1'b0;  full_len = 1'b0;  full_type = 1'b0;
        do_tc = 1'b0;
        prod = '0;
        total = '0;  offset = '0;  remain = '0;  blen = '0;
        res = '0;
        do_line_end = 1'b0;

        if (in_take)
        begin
            cnt_next = (cnt_reg == LEN_MAX) ? LEN_MAX : cnt_reg + 1'b1;

            // method token
            if (!tok_reg)
            begin
                if (b.ws)
                begin
                    tok_next = 1'b1;
                    if (inv_reg && mm_reg == 4'd6)       meth_next = METH_INVITE;
                    else if (regm_reg && mm_reg == 4'd8) meth_next = METH_REGISTER;
                    else                                  meth_next = METH_UNKNOWN;
                end
                else
                begin
                    inv_next  = inv_reg && mm_reg < 4'd6 && b.lc == pat_invite(mm_reg);
                    regm_next = regm_reg && mm_reg < 4'd8 && b.lc == pat_register(mm_reg);
                    if (mm_reg < 4'd9) mm_next = mm_reg + 4'd1;
                end
            end

            // blank line search
            if (!bfound_reg)
            begin
                if (b.lf)
                begin
                    if (snl_reg)
                    begin
                        bfound_next = 1'b1;
                        bstart_next = cnt_next;
                    end
                    else
                    begin
                        snl_next = 1'b1;
                    end
                end
                else if (!b.cr)
                begin
                    snl_next = 1'b0;
                end
            end

            // header lines
            if (ifl_reg)
            begin
                if (b.lf) ifl_next = 1'b0;
            end
            else if (!b.lf)
            begin
                unique case (ph_reg)
                    PH_NAME:
                    begin
                        if (b.colon || b.ws)
                        begin
                            full_len  = clen_reg && np_reg == 4'd14;
                            full_type = ctyp_reg && np_reg == 4'd12;
                            if (full_len || full_type)
                            begin
                                sel_next = full_len;
                                if (b.colon)
                                begin
                                    hit_len  = full_len;
                                    hit_type = !full_len;
                                    ph_next  = PH_LEAD;
                                end
                                else
                                begin
                                    ph_next = PH_TAIL;
                                end
                            end
                            else
                            begin
                                ph_next = PH_SKIP;
                            end
                        end
                        else
                        begin
                            clen_next = clen_reg && np_reg < 4'd14 && b.lc == pat_clen(np_reg);
                            ctyp_next = ctyp_reg && np_reg < 4'd12 && b.lc == pat_ctype(np_reg);
                            if (np_reg < 4'd15) np_next = np_reg + 4'd1;
                            if (!clen_next && !ctyp_next) ph_next = PH_SKIP;
                        end
                    end
                    PH_TAIL:
                    begin
                        if (!b.ws) ph_next = PH_SKIP;
                    end
                    PH_LEAD:
                    begin
                        if (!b.ws)
                        begin
                            if (sel_reg)
                            begin
                                if (b.digit)
                                begin
                                    lnum_next = 1'b1;
                                    lval_next = LEN_BITS'(b.dval);
                                    ph_next   = PH_VALUE;
                                end
                                else
                                begin
                                    ph_next = PH_SKIP;
                                end
                            end
                            else
                            begin
                                do_tc   = 1'b1;
                                ph_next = PH_VALUE;
                            end
                        end
                    end
                    PH_VALUE:
                    begin
                        if (sel_reg)
                        begin
                            if (b.digit)
                            begin
                                prod = ((LEN_BITS+4)'(lval_reg) << 3) + ((LEN_BITS+4)'(lval_reg) << 1)
                                     + (LEN_BITS+4)'(b.dval);
                                lval_next = (prod > (LEN_BITS+4)'(LEN_MAX)) ? LEN_MAX
                                                                            : LEN_BITS'(prod);
                            end
                            else
                            begin
                                ph_next = PH_SKIP;
                            end
                        end
                        else if (b.ws)
                        begin
                            tgap_next = 1'b1;
                        end
                        else
                        begin
                            do_tc = 1'b1;
                        end
                    end
                    PH_SKIP: ;
                    default: ;
                endcase
            end

            // one content-type value character
            if (do_tc)
            begin
                tbad_next = tbad_reg || tgap_reg
                          || !(tpos_reg < 5'd15 && b.lc == pat_sdp(tpos_reg[3:0]));
                if (tpos_reg < 5'd16) tpos_next = tpos_reg + 5'd1;
                tany_next = 1'b1;
                tgap_next = 1'b0;
            end

            // end of a header line: at LF, or the unterminated last line
            do_line_end = !ifl_reg && (b.lf || b.last);
            if (do_line_end)
            begin
                unique case (ph_next)
                    PH_NAME:
                    begin
                        if (clen_next && np_next == 4'd14)      hit_len = 1'b1;
                        else if (ctyp_next && np_next == 4'd12) hit_type = 1'b1;
                    end
                    PH_TAIL:
                    begin
                        hit_len  = sel_next;
                        hit_type = !sel_next;
                    end
                    PH_VALUE:
                    begin
                        if (!sel_next)
                        begin
                            if (!tany_next)                             tcls_next = KIND_NONE;
                            else if (!tbad_next && tpos_next == 5'd15) tcls_next = KIND_SDP;
                            else                                        tcls_next = KIND_OTHER;
                        end
                    end
                    PH_LEAD, PH_SKIP: ;
                    default: ;
                endcase
            end

            if (hit_len)
            begin
                ldone_next = 1'b1;
                lnum_next  = 1'b0;
                lval_next  = '0;
            end
            if (hit_type)
            begin
                tdone_next = 1'b1;
                tcls_next  = KIND_NONE;
                tpos_next  = '0;
                tbad_next  = 1'b0;
                tgap_next  = 1'b0;
                tany_next  = 1'b0;
            end

            // new line starts after the first LF and after every line end
            if ((ifl_reg && b.lf) || do_line_end)
            begin
                ph_next   = PH_NAME;
                np_next   = '0;
                clen_next = !ldone_next;
                ctyp_next = !tdone_next;
            end

            if (b.last)
            begin
                if (!tok_reg && !b.ws)
                begin
                    if (inv_next && mm_next == 4'd6)       meth_next = METH_INVITE;
                    else if (regm_next && mm_next == 4'd8) meth_next = METH_REGISTER;
                    else                                    meth_next = METH_UNKNOWN;
                end
                total  = cnt_next;
                offset = bfound_next ? bstart_next : total;
                remain = total - offset;
                if (meth_next == METH_INVITE)
                begin
                    blen = (lnum_next && lval_next < remain) ? lval_next : remain;
                    res.content_kind = tcls_next;
                end
                res.method_code = meth_next;
                res.body_offset = 16'(offset);
                res.body_length = 16'(blen);

                // back to the start state for the next datagram
                cnt_next = '0;     mm_next = '0;      inv_next = 1'b1;   regm_next = 1'b1;
                tok_next = 1'b0;   meth_next = METH_UNKNOWN;             ifl_next = 1'b1;
                snl_next = 1'b0;   bstart_next = '0;  bfound_next = 1'b0;
                np_next = '0;      clen_next = 1'b1;  ctyp_next = 1'b1;  sel_next = 1'b0;
                ph_next = PH_NAME; ldone_next = 1'b0; lval_next = '0;    lnum_next = 1'b0;
                tdone_next = 1'b0; tpos_next = '0;    tbad_next = 1'b0;  tgap_next = 1'b0;
                tany_next = 1'b0;  tcls_next = KIND_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;     mm_reg <= '0;      inv_reg <= 1'b1;   regm_reg <= 1'b1;
            tok_reg <= 1'b0;   meth_reg <= METH_UNKNOWN;             ifl_reg <= 1'b1;
            snl_reg <= 1'b0;   bstart_reg <= '0;  bfound_reg <= 1'b0;
            np_reg <= '0;      clen_reg <= 1'b1;  ctyp_reg <= 1'b1;  sel_reg <= 1'b0;
            ph_reg <= PH_NAME; ldone_reg <= 1'b0; lval_reg <= '0;    lnum_reg <= 1'b0;
            tdone_reg <= 1'b0; tpos_reg <= '0;    tbad_reg <= 1'b0;  tgap_reg <= 1'b0;
            tany_reg <= 1'b0;  tcls_reg <= KIND_NONE;
        end
        else
        begin
            cnt_reg <= cnt_next;     mm_reg <= mm_next;       inv_reg <= inv_next;
            regm_reg <= regm_next;   tok_reg <= tok_next;     meth_reg <= meth_next;
            ifl_reg <= ifl_next;     snl_reg <= snl_next;     bstart_reg <= bstart_next;
            bfound_reg <= bfound_next; np_reg <= np_next;     clen_reg <= clen_next;
            ctyp_reg <= ctyp_next;   sel_reg <= sel_next;     ph_reg <= ph_next;
            ldone_reg <= ldone_next; lval_reg <= lval_next;   lnum_reg <= lnum_next;
            tdone_reg <= tdone_next; tpos_reg <= tpos_next;   tbad_reg <= tbad_next;
            tgap_reg <= tgap_next;   tany_reg <= tany_next;   tcls_reg <= tcls_next;
        end
    end

endmodule

`default_nettype wire

// File: design/sip_request_header_scanner_top.sv
// ----------------------------------------------------------------------------
// sip_request_header_scanner_top - SIP request header scanner
// Streams one SIP request datagram a byte at a time and reports the method,
// body offset, clamped body length and content-type class at its last byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive data_byte/last_byte and raise push; the item is taken
//   on a clock edge where full is low. Mark the final byte with last_byte.
//   Result channel: while empty is low the oldest result sits on
//   method_code/body_offset/body_length/content_kind; pop takes it.
//   Throughput: one byte per cycle while the result queue is not full. The
//   classifier feeds a two-entry byte queue; the scanner retires one queued
//   byte per cycle unless it holds. A last byte is registered in the byte
//   queue; once scanned, its result is registered and empty goes low.
//   Stalls: results wait in a two-entry result queue. Once it is full the
//   scanner holds, the byte queue fills, and full rises; nothing is dropped.
//   Reset: rst_n low clears both queues and puts the scanner in its start
//   state (first line, method match restarted); no sweep is needed.
//   After each datagram the scanner returns to the same start state.
// ----------------------------------------------------------------------------
`default_nettype none

module sip_request_header_scanner_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    input  wire logic        push,
    output logic             full,
    output logic [1:0]       method_code,
    output logic [15:0]      body_offset,
    output logic [15:0]      body_length,
    output logic [1:0]       content_kind,
    output logic             empty,
    input  wire logic        pop
);
    import srhs_pkg::*;

    byte_t cls, q_item;
    logic  q_valid, scan_take, res_full, res_push;
    res_t  scan_res, out_res;

    // front: classify incoming byte
    srhs_front u_front (
        .data_byte (data_byte),
        .last_byte (last_byte),
        .cls       (cls)
    );

    // short queue between classifier and scanner
    srhs_byte_q u_byte_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls),
        .full    (full),
        .valid   (q_valid),
        .rd_en   (scan_take),
        .rd_data (q_item)
    );

    // back: per-byte scan state
    srhs_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_item  (q_item),
        .in_take  (scan_take),
        .res_full (res_full),
        .res_push (res_push),
        .res      (scan_res)
    );

    // result buffer toward the receiver
    srhs_res_q u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (scan_res),
        .full    (res_full),
        .empty   (empty),
        .rd_en   (pop),
        .rd_data (out_res)
    );

    assign method_code  = out_res.method_code;
    assign body_offset  = out_res.body_offset;
    assign body_length  = out_res.body_length;
    assign content_kind = out_res.content_kind;

endmodule

`default_nettype wire

// File: design/srhs_checker.sv
// ----------------------------------------------------------------------------
// srhs_checker - port-level checks for the header scanner
// Watches the top level's ports; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module srhs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        full,
    input wire logic [1:0]  method_code,
    input wire logic [15:0] body_length,
    input wire logic [1:0]  content_kind,
    input wire logic        empty,
    input wire logic        pop
);
    import srhs_pkg::*;

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty && !full)
        else $error("queues not empty during reset");

    a_codes_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> method_code != 2'd3 && content_kind != 2'd3)
        else $error("result carries an undefined code");

    a_invite_only: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && method_code != METH_INVITE |-> body_length == 16'd0
                                                && content_kind == KIND_NONE)
        else $error("length or content kind reported for a non-INVITE item");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(method_code) && $stable(body_length))
        else $error("waiting result changed before pop");

endmodule

bind sip_request_header_scanner_top srhs_checker u_srhs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .full         (full),
    .method_code  (method_code),
    .body_length  (body_length),
    .content_kind (content_kind),
    .empty        (empty),
    .pop          (pop)
);

`default_nettype wire
